>>> hw/rtl/hdu_pkg.sv
package hdu_pkg;

    localparam logic [4:0]  POS_LAST       = 5'd28;
    localparam logic [4:0]  POS_MAX        = 5'd31;
    localparam logic [13:0] EARLIEST_RESET = 14'd2020;
    localparam logic [13:0] EPOCH_YEAR     = 14'd1970;
    localparam logic [13:0] LAST_YEAR      = 14'd9999;
    localparam int          HDU_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [23:0] EPOCH_SHIFT = 24'd719468;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;

    localparam logic [7:0] MONTH_NAME [12][3] = '{
        '{8'h4A, 8'h61, 8'h6E}, '{8'h46, 8'h65, 8'h62}, '{8'h4D, 8'h61, 8'h72},
        '{8'h41, 8'h70, 8'h72}, '{8'h4D, 8'h61, 8'h79}, '{8'h4A, 8'h75, 8'h6E},
        '{8'h4A, 8'h75, 8'h6C}, '{8'h41, 8'h75, 8'h67}, '{8'h53, 8'h65, 8'h70},
        '{8'h4F, 8'h63, 8'h74}, '{8'h4E, 8'h6F, 8'h76}, '{8'h44, 8'h65, 8'h63}
    };

    // February allows 29 here; the leap year test follows in the back end.
    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Day of a year that starts on the first of March, for the first of each month.
    localparam logic [8:0] MONTH_DOY [12] = '{
        9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92,
        9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
    };

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] stamp;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_LEAP,
        BK_DAYS,
        BK_SECS
    } t_back_state;

    function automatic logic [3:0] first_month(input logic [11:0] mask);
        logic [3:0] m;
        m = 4'd0;
        for (int k = 11; k >= 0; k--) begin
            if (mask[k]) begin
                m = 4'(k + 1);
            end
        end
        return m;
    endfunction

endpackage

>>> hw/rtl/hdu_if.sv
interface hdu_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_in;
    logic        final_char;
    logic [31:0] stamp_ms;

    modport source (output valid, output char_in, output final_char, output stamp_ms,
                    input ready);
    modport sink (input valid, input char_in, input final_char, input stamp_ms,
                  output ready);
endinterface

interface hdu_cfg_if;
    logic        valid;
    logic        ready;
    logic [13:0] earliest_year;

    modport source (output valid, output earliest_year, input ready);
    modport sink (input valid, input earliest_year, output ready);
endinterface

interface hdu_out_if;
    logic        valid;
    logic        ready;
    logic        date_ok;
    logic [37:0] unix_seconds;
    logic [31:0] stamp_ms_out;

    modport source (output valid, output date_ok, output unix_seconds, output stamp_ms_out,
                    input ready);
    modport sink (input valid, input date_ok, input unix_seconds, input stamp_ms_out,
                  output ready);
endinterface

>>> hw/rtl/http_date_to_unix_seconds.sv
// Channel   Direction  Word
// i_in_ch   in         char_in[7:0], final_char, stamp_ms[31:0]
// i_cfg_ch  in         earliest_year[13:0], always ready
// o_out_ch  out        date_ok, unix_seconds[37:0], stamp_ms_out[31:0]
//
// The parser takes one byte per cycle while the queue is not full.
// The result passes through the queue hop and the four steps of the shared date arithmetic
// unit (multiply, leap, days, seconds) before it reaches the output register.
// A full queue stalls input; the back end holds in its last step while the output is stalled.
// Reset is synchronous and clears the parse state, the queue and the output valid.
module http_date_to_unix_seconds
    import hdu_pkg::*;
#(
    parameter int QUEUE_DEPTH = HDU_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hdu_in_if.sink     i_in_ch,
    hdu_cfg_if.sink    i_cfg_ch,
    hdu_out_if.source  o_out_ch
);

    logic push;
    logic pop;
    logic queue_full;
    logic queue_valid;
    t_job push_job;
    t_job head_job;

    hdu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (i_in_ch),
        .i_cfg_ch     (i_cfg_ch),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    hdu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_job   (head_job)
    );

    hdu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_out_ch (o_out_ch)
    );

endmodule

>>> hw/rtl/hdu_front.sv
module hdu_front
    import hdu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hdu_in_if.sink    i_in_ch,
    hdu_cfg_if.sink   i_cfg_ch,
    input  logic      i_queue_full,
    output logic      o_push,
    output t_job      o_job
);

    logic [13:0] r_earliest_year;
    logic [4:0]  r_byte_pos,  n_byte_pos;
    logic        r_fault,     n_fault;
    logic [11:0] r_mask,      n_mask;
    logic [6:0]  r_day,       n_day;
    logic [13:0] r_year,      n_year;
    logic [6:0]  r_hour,      n_hour;
    logic [6:0]  r_minute,    n_minute;
    logic [6:0]  r_second,    n_second;

    logic       accept;
    logic       is_digit;
    logic [3:0] digit;
    logic [1:0] name_idx;
    logic [3:0] month;
    logic [4:0] month_len;
    logic       ok;

    assign i_cfg_ch.ready = 1'b1;
    assign i_in_ch.ready  = !i_queue_full;
    assign accept         = i_in_ch.valid && i_in_ch.ready;

    assign is_digit = (i_in_ch.char_in >= CH_0) && (i_in_ch.char_in <= CH_9);
    assign digit    = 4'(i_in_ch.char_in - CH_0);
    assign name_idx = 2'(r_byte_pos - 5'd8);

    always_comb begin
        n_fault  = r_fault;
        n_mask   = r_mask;
        n_day    = r_day;
        n_year   = r_year;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_byte_pos = (r_byte_pos == POS_MAX) ? r_byte_pos : r_byte_pos + 5'd1;
        unique case (r_byte_pos)
            5'd0, 5'd1, 5'd2: begin
            end
            5'd3: begin
                if (i_in_ch.char_in != CH_COMMA) n_fault = 1'b1;
            end
            5'd4, 5'd7, 5'd11, 5'd16, 5'd25: begin
                if (i_in_ch.char_in != CH_SPACE) n_fault = 1'b1;
            end
            5'd19, 5'd22: begin
                if (i_in_ch.char_in != CH_COLON) n_fault = 1'b1;
            end
            5'd5, 5'd6: begin
                if (is_digit) n_day = 7'(r_day * 7'd10 + {3'd0, digit});
                else n_fault = 1'b1;
            end
            5'd12, 5'd13, 5'd14, 5'd15: begin
                if (is_digit) n_year = 14'(r_year * 14'd10 + {10'd0, digit});
                else n_fault = 1'b1;
            end
            5'd17, 5'd18: begin
                if (is_digit) n_hour = 7'(r_hour * 7'd10 + {3'd0, digit});
                else n_fault = 1'b1;
            end
            5'd20, 5'd21: begin
                if (is_digit) n_minute = 7'(r_minute * 7'd10 + {3'd0, digit});
                else n_fault = 1'b1;
            end
            5'd23, 5'd24: begin
                if (is_digit) n_second = 7'(r_second * 7'd10 + {3'd0, digit});
                else n_fault = 1'b1;
            end
            5'd8, 5'd9, 5'd10: begin
                for (int k = 0; k < 12; k++) begin
                    if (MONTH_NAME[k][name_idx] != i_in_ch.char_in) n_mask[k] = 1'b0;
                end
            end
            5'd26: begin
                if (i_in_ch.char_in != CH_G) n_fault = 1'b1;
            end
            5'd27: begin
                if (i_in_ch.char_in != CH_M) n_fault = 1'b1;
            end
            5'd28: begin
                if (i_in_ch.char_in != CH_T) n_fault = 1'b1;
            end
            default: begin
                n_fault = 1'b1;
            end
        endcase
    end

    always_comb begin
        month     = first_month(r_mask);
        month_len = (month == 4'd0) ? 5'd0 : MONTH_DAYS[month - 4'd1];
        ok = (r_byte_pos == POS_LAST) && !n_fault && (month != 4'd0)
            && (r_year >= r_earliest_year) && (r_year >= EPOCH_YEAR)
            && (r_year <= LAST_YEAR) && (r_day >= 7'd1) && (r_day <= {2'd0, month_len})
            && (r_hour <= 7'd23) && (r_minute <= 7'd59) && (r_second <= 7'd60);
        o_job.ok     = ok;
        o_job.year   = r_year;
        o_job.month  = month;
        o_job.day    = r_day[4:0];
        o_job.hour   = r_hour[4:0];
        o_job.minute = r_minute[5:0];
        o_job.second = r_second[5:0];
        o_job.stamp  = i_in_ch.stamp_ms;
    end

    assign o_push = accept && i_in_ch.final_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earliest_year <= EARLIEST_RESET;
        end else if (i_cfg_ch.valid) begin
            r_earliest_year <= i_cfg_ch.earliest_year;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_byte_pos <= 5'd0;
            r_fault    <= 1'b0;
            r_mask     <= '1;
            r_day      <= '0;
            r_year     <= '0;
            r_hour     <= '0;
            r_minute   <= '0;
            r_second   <= '0;
        end else if (accept) begin
            r_byte_pos <= n_byte_pos;
            r_fault    <= n_fault;
            r_mask     <= n_mask;
            r_day      <= n_day;
            r_year     <= n_year;
            r_hour     <= n_hour;
            r_minute   <= n_minute;
            r_second   <= n_second;
        end
    end

    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_byte_pos == 5'd0) && (r_mask == 12'hFFF) && !r_fault)
        else $error("Parse state was not cleared after the final byte.");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !o_push && r_byte_pos == POS_MAX) |=> (r_byte_pos == POS_MAX) && r_fault)
        else $error("Byte position left saturation or the fault was lost.");

    a_ok_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.ok) |-> (r_byte_pos == POS_LAST) && $onehot(r_mask))
        else $error("A date was accepted with a wrong length or month.");

endmodule

>>> hw/rtl/hdu_queue.sv
module hdu_queue
    import hdu_pkg::*;
#(
    parameter int DEPTH = HDU_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("Word pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("Word popped from an empty queue.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("Queue count exceeds its depth.");

endmodule

>>> hw/rtl/hdu_back.sv
module hdu_back
    import hdu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_job,
    output logic       o_pop,
    hdu_out_if.source  o_out_ch
);

    t_back_state r_state, n_state;

    t_job        r_job;
    logic [26:0] r_p100;
    logic [24:0] r_p400;
    logic [16:0] r_tod;
    logic        r_ok;
    logic [13:0] r_ys;
    logic [11:0] r_d4;
    logic [7:0]  r_d100;
    logic [5:0]  r_d400;
    logic [21:0] r_days;

    logic        r_out_valid;
    logic        r_date_ok;
    logic [37:0] r_secs;
    logic [31:0] r_stamp;

    logic        out_load;
    logic        out_free;

    logic [7:0]  q100;
    logic [5:0]  q400;
    logic        z4;
    logic        z100;
    logic        z400;
    logic        leap;
    logic        early;
    logic        feb_bad;
    logic [5:0]  sec_adj;
    logic [23:0] days_sum;
    logic [37:0] secs_sum;

    assign out_free = !r_out_valid || o_out_ch.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_valid) n_state = BK_MUL;
            BK_MUL:  n_state = BK_LEAP;
            BK_LEAP: n_state = BK_DAYS;
            BK_DAYS: n_state = BK_SECS;
            BK_SECS: if (out_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            BK_IDLE: o_pop = i_valid;
            BK_SECS: out_load = out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        sec_adj  = (r_job.second == 6'd60) ? 6'd59 : r_job.second;
        q100     = r_p100[RECIP_SHIFT +: 8];
        q400     = r_p400[RECIP_SHIFT +: 6];
        z4       = (r_job.year[1:0] == 2'd0);
        z100     = (14'(q100 * 14'd100) == r_job.year);
        z400     = (14'(q400 * 14'd400) == r_job.year);
        leap     = z4 && (!z100 || z400);
        early    = (r_job.month <= MONTH_FEB);
        feb_bad  = (r_job.month == MONTH_FEB) && (r_job.day == 5'd29) && !leap;
        days_sum = 24'(r_ys) * 24'd365 + 24'(r_d4) - 24'(r_d100) + 24'(r_d400)
            + 24'(MONTH_DOY[r_job.month - 4'd1]) + 24'(r_job.day) - 24'd1 - EPOCH_SHIFT;
        secs_sum = 38'(r_days) * 38'(SECS_PER_DAY) + 38'(r_tod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == BK_MUL) begin
            r_p100 <= 27'(r_job.year * RECIP_100);
            r_p400 <= 25'(r_job.year[13:2] * RECIP_100);
            r_tod  <= 17'(r_job.hour * 17'd3600) + 17'(r_job.minute * 17'd60)
                + 17'(sec_adj);
        end
        if (r_state == BK_LEAP) begin
            r_ok   <= r_job.ok && !feb_bad;
            r_ys   <= r_job.year - 14'(early);
            r_d4   <= r_job.year[13:2] - 12'(early && z4);
            r_d100 <= q100 - 8'(early && z100);
            r_d400 <= q400 - 6'(early && z400);
        end
        if (r_state == BK_DAYS) begin
            r_days <= days_sum[21:0];
        end
        if (out_load) begin
            r_date_ok <= r_ok;
            r_secs    <= r_ok ? secs_sum : '0;
            r_stamp   <= r_job.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.date_ok      = r_date_ok;
    assign o_out_ch.unix_seconds = r_secs;
    assign o_out_ch.stamp_ms_out = r_stamp;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_date_ok) |-> (r_secs == '0))
        else $error("Rejected date carries nonzero seconds.");

    a_secs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_date_ok) |-> (r_secs < 38'd253402300800))
        else $error("Seconds beyond the last representable date.");

    a_finish_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SECS && !r_out_valid) |=> r_out_valid && (r_state == BK_IDLE))
        else $error("Finished word did not reach the output register.");

endmodule

>>> bench/http_date_to_unix_seconds_tb.sv
`timescale 1ns / 1ps

module http_date_to_unix_seconds_tb;
    import hdu_pkg::*;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic [31:0] stamp;
    } t_date_byte;

    typedef struct packed {
        logic        ok;
        logic [37:0] secs;
        logic [31:0] stamp;
    } t_conversion;

    localparam logic [8*36-1:0] MONTH_TEXT   = "JanFebMarAprMayJunJulAugSepOctNovDec";
    localparam logic [8*21-1:0] WEEKDAY_TEXT = "MonTueWedThuFriSatSun";
    localparam int RANDOM_BYTES = 1250;
    localparam int PHASE_BYTES  = 250;

    logic clk = 1'b0;
    logic rst_n;

    hdu_in_if  in_ch ();
    hdu_cfg_if cfg_ch ();
    hdu_out_if out_ch ();

    http_date_to_unix_seconds dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_in_ch  (in_ch),
        .i_cfg_ch (cfg_ch),
        .o_out_ch (out_ch)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    t_date_byte  byte_backlog [$];
    t_conversion due_conversions [$];
    logic [7:0]  text_buf [$];

    logic [4:0]  dp_pos;
    logic        dp_fault;
    logic [11:0] dp_months;
    logic [6:0]  dp_day;
    logic [13:0] dp_year;
    logic [6:0]  dp_hour;
    logic [6:0]  dp_minute;
    logic [6:0]  dp_second;
    logic [13:0] earliest_year_reg;

    bit idling_on = 1'b1;
    int send_gap;
    int recv_gap;
    int error_count;
    int bytes_queued;
    int bytes_sent;
    int dates_accepted;
    int dates_rejected;
    int cfg_writes;
    t_date_byte  next_byte;
    t_conversion want;

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 40) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic restart_parse();
        dp_pos    = '0;
        dp_fault  = 1'b0;
        dp_months = '1;
        dp_day    = '0;
        dp_year   = '0;
        dp_hour   = '0;
        dp_minute = '0;
        dp_second = '0;
    endtask

    function automatic logic [7:0] month_char(input int k, input int i);
        return MONTH_TEXT[8*(35 - (3*k + i)) +: 8];
    endfunction

    function automatic bit has_feb29(input int y);
        return (y % 4 == 0) && (y % 100 != 0 || y % 400 == 0);
    endfunction

    function automatic int days_before_month(input int m);
        case (m)
            1:       return 0;
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            default: return 334;
        endcase
    endfunction

    function automatic logic [13:0] shift_in_digit(input logic [13:0] acc, input logic [7:0] c);
        if (c < CH_0 || c > CH_9) begin
            dp_fault = 1'b1;
            return acc;
        end
        return 14'(acc * 10 + (c - CH_0));
    endfunction

    task automatic parse_date_byte(input logic [7:0] c, input logic fin, input logic [31:0] stamp);
        logic [4:0]  at;
        int          month;
        int          month_len;
        int          y;
        int          py;
        int          sec;
        longint      days;
        logic        ok;
        t_conversion res;
        at = dp_pos;
        case (at)
            5'd0, 5'd1, 5'd2: ;
            5'd3: if (c != CH_COMMA) dp_fault = 1'b1;
            5'd4, 5'd7, 5'd11, 5'd16, 5'd25: if (c != CH_SPACE) dp_fault = 1'b1;
            5'd19, 5'd22: if (c != CH_COLON) dp_fault = 1'b1;
            5'd5, 5'd6: dp_day = 7'(shift_in_digit(14'(dp_day), c));
            5'd12, 5'd13, 5'd14, 5'd15: dp_year = shift_in_digit(dp_year, c);
            5'd17, 5'd18: dp_hour = 7'(shift_in_digit(14'(dp_hour), c));
            5'd20, 5'd21: dp_minute = 7'(shift_in_digit(14'(dp_minute), c));
            5'd23, 5'd24: dp_second = 7'(shift_in_digit(14'(dp_second), c));
            5'd8, 5'd9, 5'd10: begin
                for (int k = 0; k < 12; k++) begin
                    if (month_char(k, int'(at) - 8) != c) dp_months[k] = 1'b0;
                end
            end
            5'd26: if (c != CH_G) dp_fault = 1'b1;
            5'd27: if (c != CH_M) dp_fault = 1'b1;
            5'd28: if (c != CH_T) dp_fault = 1'b1;
            default: dp_fault = 1'b1;
        endcase
        if (at != POS_MAX) dp_pos = at + 5'd1;
        if (fin) begin
            month = 0;
            for (int k = 0; k < 12; k++) begin
                if (month == 0 && dp_months[k]) month = k + 1;
            end
            y = int'(dp_year);
            case (month)
                2:           month_len = has_feb29(y) ? 29 : 28;
                4, 6, 9, 11: month_len = 30;
                default:     month_len = 31;
            endcase
            ok = (at == POS_LAST) && !dp_fault && month != 0
                && dp_year >= earliest_year_reg && dp_year >= EPOCH_YEAR
                && dp_year <= LAST_YEAR && dp_day >= 1 && dp_day <= month_len
                && dp_hour <= 23 && dp_minute <= 59 && dp_second <= 60;
            res.ok    = ok;
            res.secs  = '0;
            res.stamp = stamp;
            if (ok) begin
                py   = y - 1;
                sec  = (dp_second == 60) ? 59 : int'(dp_second);
                days = 365 * longint'(y - 1970) + (py / 4 - py / 100 + py / 400)
                    - (1969 / 4 - 1969 / 100 + 1969 / 400)
                    + days_before_month(month) + dp_day - 1
                    + ((month > 2 && has_feb29(y)) ? 1 : 0);
                res.secs = 38'(days * SECS_PER_DAY + dp_hour * 3600 + dp_minute * 60 + sec);
            end
            due_conversions.push_back(res);
            restart_parse();
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                parse_date_byte(in_ch.char_in, in_ch.final_char, in_ch.stamp_ms);
                bytes_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 15);
                    in_ch.valid <= 1'b0;
                end else if (byte_backlog.size() != 0) begin
                    next_byte = byte_backlog.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.char_in    <= next_byte.ch;
                    in_ch.final_char <= next_byte.fin;
                    in_ch.stamp_ms   <= next_byte.stamp;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (due_conversions.size() == 0) begin
                    flag_error($sformatf("unexpected word ok=%0d secs=%0d stamp=%h",
                        out_ch.date_ok, out_ch.unix_seconds, out_ch.stamp_ms_out));
                end else begin
                    want = due_conversions.pop_front();
                    if (out_ch.date_ok !== want.ok) begin
                        flag_error($sformatf("date_ok %0d, expected %0d",
                            out_ch.date_ok, want.ok));
                    end
                    if (out_ch.unix_seconds !== want.secs) begin
                        flag_error($sformatf("unix_seconds %0d, expected %0d",
                            out_ch.unix_seconds, want.secs));
                    end
                    if (out_ch.stamp_ms_out !== want.stamp) begin
                        flag_error($sformatf("stamp_ms_out %h, expected %h",
                            out_ch.stamp_ms_out, want.stamp));
                    end
                    if (want.ok) begin
                        dates_accepted++;
                    end else begin
                        dates_rejected++;
                    end
                end
            end
            if (recv_gap != 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 15);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic add_number(input int value, input int digits);
        int scale;
        scale = 1;
        repeat (digits - 1) scale *= 10;
        repeat (digits) begin
            text_buf.push_back(8'(CH_0 + (value / scale) % 10));
            scale /= 10;
        end
    endtask

    task automatic build_date(input int wd, input int mo, input int d, input int y,
                              input int h, input int mi, input int s);
        text_buf.delete();
        for (int i = 0; i < 3; i++) text_buf.push_back(WEEKDAY_TEXT[8*(20 - (3*wd + i)) +: 8]);
        text_buf.push_back(CH_COMMA);
        text_buf.push_back(CH_SPACE);
        add_number(d, 2);
        text_buf.push_back(CH_SPACE);
        for (int i = 0; i < 3; i++) text_buf.push_back(month_char(mo, i));
        text_buf.push_back(CH_SPACE);
        add_number(y, 4);
        text_buf.push_back(CH_SPACE);
        add_number(h, 2);
        text_buf.push_back(CH_COLON);
        add_number(mi, 2);
        text_buf.push_back(CH_COLON);
        add_number(s, 2);
        text_buf.push_back(CH_SPACE);
        text_buf.push_back(CH_G);
        text_buf.push_back(CH_M);
        text_buf.push_back(CH_T);
    endtask

    task automatic send_text();
        t_date_byte b;
        foreach (text_buf[i]) begin
            b.ch    = text_buf[i];
            b.fin   = (i == text_buf.size() - 1);
            b.stamp = $urandom();
            byte_backlog.push_back(b);
        end
        bytes_queued += text_buf.size();
        text_buf.delete();
    endtask

    task automatic send_date(input int wd, input int mo, input int d, input int y,
                             input int h, input int mi, input int s);
        build_date(wd, mo, d, y, h, mi, s);
        send_text();
    endtask

    task automatic send_random_date();
        int kind;
        int mo;
        int d;
        int y;
        int h;
        int mi;
        int s;
        kind = $urandom_range(0, 99);
        mo   = $urandom_range(0, 11);
        d    = $urandom_range(1, 31);
        h    = $urandom_range(0, 23);
        mi   = $urandom_range(0, 59);
        s    = $urandom_range(0, 60);
        case ($urandom_range(0, 9))
            0:       y = $urandom_range(0, 9999);
            1:       y = $urandom_range(9990, 9999);
            default: y = $urandom_range(1965, 2110);
        endcase
        if (kind < 8) begin
            mo = 1;
            d  = 29;
        end else if (kind < 22) begin
            case ($urandom_range(0, 3))
                0:       d  = $urandom_range(0, 99);
                1:       h  = $urandom_range(0, 99);
                2:       mi = $urandom_range(0, 99);
                default: s  = $urandom_range(0, 99);
            endcase
        end
        build_date($urandom_range(0, 6), mo, d, y, h, mi, s);
        if (kind >= 70 && kind < 82) begin
            text_buf[$urandom_range(0, 28)] = $urandom_range(0, 1) ? 8'($urandom())
                                                                   : 8'($urandom_range(32, 126));
        end else if (kind >= 82 && kind < 87) begin
            repeat ($urandom_range(1, 28)) text_buf.pop_back();
        end else if (kind >= 87 && kind < 91) begin
            repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom()));
        end else if (kind >= 91) begin
            text_buf.delete();
            repeat ($urandom_range(1, 40)) text_buf.push_back(8'($urandom()));
        end
        send_text();
    endtask

    task automatic drain_all();
        do @(negedge clk);
        while (byte_backlog.size() != 0 || in_ch.valid || due_conversions.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_earliest_year(input logic [13:0] year);
        @(posedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.earliest_year <= year;
        do @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        earliest_year_reg = year;
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int random_start;
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.char_in        = '0;
        in_ch.final_char     = 1'b0;
        in_ch.stamp_ms       = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.earliest_year = '0;
        out_ch.ready         = 1'b0;
        earliest_year_reg    = EARLIEST_RESET;
        restart_parse();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_date(5, 7, 8, 2026, 12, 34, 56);
        send_date(2, 0, 1, 2020, 0, 0, 0);
        send_date(1, 11, 31, 2019, 23, 59, 59);
        send_date(4, 11, 31, 9999, 23, 59, 60);
        send_date(3, 1, 29, 2024, 6, 0, 0);
        send_date(0, 1, 29, 2100, 6, 0, 0);
        send_date(0, 3, 31, 2021, 1, 2, 3);
        send_date(0, 3, 0, 2021, 1, 2, 3);
        send_date(0, 3, 30, 2021, 24, 0, 0);
        send_date(0, 3, 30, 2021, 23, 60, 0);
        send_date(0, 3, 30, 2021, 23, 59, 61);
        send_date(2, 9, 15, 2030, 99, 99, 99);
        build_date(5, 7, 8, 2026, 12, 34, 56);
        text_buf[0] = 8'h00;
        text_buf[1] = 8'hFF;
        send_text();
        build_date(5, 7, 8, 2026, 12, 34, 56);
        text_buf[8] = "a";
        send_text();
        build_date(5, 7, 8, 2026, 12, 34, 56);
        text_buf[28] = "t";
        send_text();
        build_date(5, 7, 8, 2026, 12, 34, 56);
        text_buf[5]  = "x";
        text_buf[12] = "/";
        text_buf[13] = ":";
        send_text();
        build_date(5, 7, 8, 2026, 12, 34, 56);
        text_buf.pop_back();
        send_text();
        build_date(5, 7, 8, 2026, 12, 34, 56);
        repeat (11) text_buf.push_back(CH_SPACE);
        send_text();
        text_buf.push_back(CH_T);
        send_text();
        drain_all();

        set_earliest_year(EPOCH_YEAR);
        send_date(3, 0, 1, 1970, 0, 0, 0);
        send_date(2, 11, 31, 1969, 23, 59, 59);
        send_date(1, 1, 29, 2000, 12, 0, 0);
        send_date(3, 0, 1, 1970, 0, 0, 60);
        drain_all();

        set_earliest_year(LAST_YEAR);
        send_date(4, 11, 31, 9998, 23, 59, 59);
        send_date(4, 0, 1, 9999, 0, 0, 0);
        drain_all();

        set_earliest_year(14'd10000);
        send_date(4, 11, 31, 9999, 23, 59, 59);
        drain_all();

        set_earliest_year(14'h3FFF);
        send_date(4, 5, 15, 2040, 8, 30, 0);
        drain_all();

        set_earliest_year(EARLIEST_RESET);
        random_start = bytes_queued;
        while (bytes_queued - random_start < RANDOM_BYTES) begin
            if (bytes_queued - random_start >= RANDOM_BYTES - 2 * PHASE_BYTES) idling_on = 1'b0;
            repeat (PHASE_BYTES / 29) send_random_date();
            drain_all();
            case ($urandom_range(0, 5))
                0:       set_earliest_year(EPOCH_YEAR);
                1:       set_earliest_year(14'($urandom_range(1970, 2100)));
                2:       set_earliest_year(14'($urandom_range(1970, 9999)));
                default: set_earliest_year(14'($urandom_range(1990, 2060)));
            endcase
        end
        drain_all();

        $display("Sent %0d date bytes under %0d register settings.", bytes_sent, cfg_writes + 1);
        $display("Checked %0d accepted and %0d rejected dates.", dates_accepted, dates_rejected);
        if (error_count == 0 && due_conversions.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
